### hw/rtl/smf_pkg.sv
`default_nettype none
package smf_pkg;

    localparam int MAX_LINE_DEF   = 6 * 1024;
    localparam int MAX_PACKET_DEF = 12288;
    localparam int QUEUE_DEPTH    = 2;

    // Result status codes.
    localparam logic [3:0] ST_READY     = 4'd0;
    localparam logic [3:0] ST_LONG_LINE = 4'd1;
    localparam logic [3:0] ST_LONE_CR   = 4'd2;
    localparam logic [3:0] ST_BAD_START = 4'd3;
    localparam logic [3:0] ST_BAD_HDR   = 4'd4;
    localparam logic [3:0] ST_DUPLICATE = 4'd5;
    localparam logic [3:0] ST_BAD_LEN   = 4'd6;
    localparam logic [3:0] ST_MISSING   = 4'd7;
    localparam logic [3:0] ST_TOO_LARGE = 4'd8;

    // Packet phase.
    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_HEAD  = 2'd1;
    localparam logic [1:0] PH_BODY  = 2'd2;

    // Header line scan state.
    localparam logic [1:0] TS_TAG   = 2'd0;
    localparam logic [1:0] TS_SPACE = 2'd1;
    localparam logic [1:0] TS_VALUE = 2'd2;
    localparam logic [1:0] TS_BAD   = 2'd3;

    // Request method scan state.
    localparam logic [1:0] MS_SCAN = 2'd0;
    localparam logic [1:0] MS_OK   = 2'd1;
    localparam logic [1:0] MS_BAD  = 2'd2;

    // Header tag indexes.
    localparam logic [2:0] TAG_VIA     = 3'd0;
    localparam logic [2:0] TAG_FROM    = 3'd1;
    localparam logic [2:0] TAG_TO      = 3'd2;
    localparam logic [2:0] TAG_CONTACT = 3'd3;
    localparam logic [2:0] TAG_CLEN    = 3'd4;
    localparam int         NUM_TAGS    = 5;

    // Lower-cased "sip/2.0 " with the first byte in the low byte.
    localparam logic [63:0] STATUS_WORD  = 64'h20302E322F706973;
    // Lower-cased " sip/2.0" with the last byte in the low byte.
    localparam logic [63:0] REQUEST_TAIL = 64'h207369702F322E30;

    typedef struct packed {
        logic [7:0] lower;
        logic       is_cr;
        logic       is_lf;
        logic       is_letter;
        logic       is_dash;
        logic       is_colon;
        logic       is_space;
        logic       is_digit;
        logic [3:0] digit;
    } t_byte_class;

    typedef struct packed {
        logic [3:0]  status;
        logic [13:0] header_len;
        logic [13:0] body_len;
        logic [12:0] method_len;
        logic [13:0] via_offset;
        logic [12:0] via_length;
        logic [13:0] from_offset;
        logic [12:0] from_length;
        logic [13:0] to_offset;
        logic [12:0] to_length;
        logic [13:0] contact_offset;
        logic [12:0] contact_length;
    } t_result;

    function automatic logic [3:0] tag_len(input logic [2:0] k);
        logic [3:0] n;
        unique case (k)
            TAG_VIA:     n = 4'd3;
            TAG_FROM:    n = 4'd4;
            TAG_TO:      n = 4'd2;
            TAG_CONTACT: n = 4'd7;
            TAG_CLEN:    n = 4'd14;
            default:     n = 4'd0;
        endcase
        return n;
    endfunction

    // Character idx of tag k, zero past its end.
    function automatic logic [7:0] tag_char(input logic [2:0] k, input logic [3:0] idx);
        logic [111:0] s;
        logic [3:0]   n;
        logic [3:0]   pos;
        unique case (k)
            TAG_VIA:     s = 112'("via");
            TAG_FROM:    s = 112'("from");
            TAG_TO:      s = 112'("to");
            TAG_CONTACT: s = 112'("contact");
            TAG_CLEN:    s = 112'("content-length");
            default:     s = '0;
        endcase
        n   = tag_len(k);
        pos = 4'(n - 4'd1 - idx);
        if (idx >= n) begin
            return 8'd0;
        end
        return s[{pos, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

### hw/rtl/smf_fifo.sv
`default_nettype none
module smf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : AW'(r_rd + 1'b1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= CW'(r_cnt + 1'b1);
            end else if (do_pop && !do_push) begin
                r_cnt <= CW'(r_cnt - 1'b1);
            end
        end
    end
endmodule
`default_nettype wire

### hw/rtl/smf_front.sv
`default_nettype none
module smf_front
    import smf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_data,
    output logic            o_full,
    output logic            o_valid,
    output t_byte_class     o_cls,
    input  wire logic       i_take
);
    localparam int CLS_W = $bits(t_byte_class);

    t_byte_class      cls;
    logic [7:0]       lb;
    logic             q_empty;
    logic [CLS_W-1:0] q_rdata;

    // Lower-case the byte and decode the classes the parser looks at.
    always_comb begin
        lb = (i_data >= 8'h41 && i_data <= 8'h5A) ? 8'(i_data + 8'd32) : i_data;
        cls.lower     = lb;
        cls.is_cr     = (i_data == 8'h0D);
        cls.is_lf     = (i_data == 8'h0A);
        cls.is_letter = (lb >= 8'h61 && lb <= 8'h7A);
        cls.is_dash   = (lb == 8'h2D);
        cls.is_colon  = (lb == 8'h3A);
        cls.is_space  = (lb == 8'h20);
        cls.is_digit  = (lb >= 8'h30 && lb <= 8'h39);
        cls.digit     = 4'(lb - 8'h30);
    end

    smf_fifo #(.WIDTH(CLS_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_wdata (cls),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_empty (q_empty),
        .o_rdata (q_rdata)
    );

    assign o_valid = !q_empty;
    assign o_cls   = t_byte_class'(q_rdata);
endmodule
`default_nettype wire

### hw/rtl/smf_back.sv
`default_nettype none
module smf_back
    import smf_pkg::*;
#(
    parameter int MAX_LINE   = MAX_LINE_DEF,
    parameter int MAX_PACKET = MAX_PACKET_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire t_byte_class i_cls,
    output logic             o_take,
    input  wire logic        i_res_full,
    output logic             o_res_push,
    output t_result          o_res
);
    localparam int PW = $clog2(MAX_PACKET + 2);
    localparam int LW = $clog2(MAX_LINE + 1);

    logic [1:0]    r_phase, n_phase;
    logic [PW-1:0] r_pkt, n_pkt;
    logic [PW-1:0] r_ls, n_ls;
    logic [LW-1:0] r_ll, n_ll;
    logic          r_cr, n_cr;
    logic [63:0]   r_first, n_first;
    logic [63:0]   r_last, n_last;
    logic [LW-1:0] r_mrun, n_mrun;
    logic [1:0]    r_ms, n_ms;
    logic [3:0]    r_tl, n_tl;
    logic [4:0]    r_cand, n_cand;
    logic [1:0]    r_ts, n_ts;
    logic [LW-1:0] r_vb, n_vb;
    logic [PW-1:0] r_acc, n_acc;
    logic          r_dv, n_dv;
    logic [4:0]    r_found, n_found;
    logic [PW-1:0] r_off [4];
    logic [PW-1:0] n_off [4];
    logic [LW-1:0] r_len [4];
    logic [LW-1:0] n_len [4];
    logic [PW-1:0] r_ht, n_ht;
    logic [PW-1:0] r_ct, n_ct;

    logic [PW-1:0] pb_inc;
    logic [PW:0]   body_end;
    logic [PW+3:0] acc_next;
    logic          fin, restart, line_end, new_line, first_dig, dig_step, hit_ok;
    logic [3:0]    code;
    logic [2:0]    hit;
    logic          is_status, is_request;

    assign o_take     = i_valid && !i_res_full;
    assign o_res_push = o_take && fin;
    assign pb_inc     = PW'(r_pkt + 1'b1);
    assign body_end   = {1'b0, r_ht} + {1'b0, r_ct};

    always_comb begin
        n_phase = r_phase; n_pkt = r_pkt; n_ls = r_ls; n_ll = r_ll; n_cr = r_cr;
        n_first = r_first; n_last = r_last; n_mrun = r_mrun; n_ms = r_ms;
        n_tl = r_tl; n_cand = r_cand; n_ts = r_ts; n_vb = r_vb; n_acc = r_acc;
        n_dv = r_dv; n_found = r_found; n_off = r_off; n_len = r_len;
        n_ht = r_ht; n_ct = r_ct;
        fin = 1'b0; restart = 1'b0; line_end = 1'b0; new_line = 1'b0;
        first_dig = 1'b0; dig_step = 1'b0; code = ST_READY;
        acc_next = '0;
        hit = TAG_VIA; hit_ok = 1'b0;
        is_status  = (r_ll > LW'(8)) && (r_first == STATUS_WORD);
        is_request = (r_ll > LW'(8)) && (r_last == REQUEST_TAIL) && (r_ms == MS_OK);

        for (int k = 0; k < NUM_TAGS; k++) begin
            if (r_cand[k] && r_tl == tag_len(3'(k))) begin
                hit    = 3'(k);
                hit_ok = 1'b1;
            end
        end

        if (r_pkt >= PW'(MAX_PACKET)) begin
            fin  = 1'b1;
            code = ST_TOO_LARGE;
        end else begin
            n_pkt = pb_inc;
            if (r_phase == PH_BODY) begin
                if ({1'b0, pb_inc} >= body_end) begin
                    fin = 1'b1;
                end
            end else if (r_cr) begin
                n_cr = 1'b0;
                if (!i_cls.is_lf) begin
                    fin  = 1'b1;
                    code = ST_LONE_CR;
                end else begin
                    line_end = 1'b1;
                end
            end else if (i_cls.is_cr) begin
                n_cr = 1'b1;
            end else if (i_cls.is_lf) begin
                line_end = 1'b1;
            end else if (r_ll >= LW'(MAX_LINE)) begin
                fin  = 1'b1;
                code = ST_LONG_LINE;
            end else begin
                n_ll = LW'(r_ll + 1'b1);
                if (r_phase == PH_START) begin
                    if (r_ll < LW'(8)) begin
                        n_first[{r_ll[2:0], 3'b000} +: 8] = r_first[{r_ll[2:0], 3'b000} +: 8]
                                                          | i_cls.lower;
                    end
                    n_last = {r_last[55:0], i_cls.lower};
                    if (r_ms == MS_SCAN) begin
                        if (i_cls.is_letter) begin
                            n_mrun = LW'(r_mrun + 1'b1);
                        end else if (i_cls.is_space && r_mrun != '0) begin
                            n_ms = MS_OK;
                        end else begin
                            n_ms = MS_BAD;
                        end
                    end
                end else begin
                    unique case (r_ts)
                        TS_TAG: begin
                            if (i_cls.is_letter || i_cls.is_dash) begin
                                for (int k = 0; k < NUM_TAGS; k++) begin
                                    if (r_tl >= tag_len(3'(k)) ||
                                        tag_char(3'(k), r_tl) != i_cls.lower) begin
                                        n_cand[k] = 1'b0;
                                    end
                                end
                                if (r_tl != 4'd15) begin
                                    n_tl = 4'(r_tl + 1'b1);
                                end
                            end else if (i_cls.is_colon && r_tl != 4'd0) begin
                                n_ts = TS_SPACE;
                            end else begin
                                n_ts = TS_BAD;
                            end
                        end
                        TS_SPACE: begin
                            if (!i_cls.is_space) begin
                                n_ts      = TS_VALUE;
                                n_vb      = r_ll;
                                first_dig = 1'b1;
                            end
                        end
                        TS_VALUE: dig_step = 1'b1;
                        TS_BAD:   ;
                        default:  ;
                    endcase
                end
            end
        end

        // Content-Length digits, saturating just above the packet limit.
        if (first_dig || dig_step) begin
            acc_next = (first_dig ? '0 : ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1))
                     + (PW+4)'(i_cls.digit);
            if (!i_cls.is_digit) begin
                n_dv = 1'b0;
            end else if (first_dig || r_dv) begin
                n_dv  = 1'b1;
                n_acc = (acc_next > (PW+4)'(MAX_PACKET)) ? PW'(MAX_PACKET + 1)
                                                        : PW'(acc_next);
            end
            if (first_dig) begin
                n_acc = i_cls.is_digit ? PW'(acc_next) : '0;
            end
        end

        if (line_end) begin
            if (r_ll == '0) begin
                if (r_phase == PH_START) begin
                    restart = 1'b1;
                end else if ((r_found & 5'h17) != 5'h17) begin
                    fin  = 1'b1;
                    code = ST_MISSING;
                end else begin
                    n_ht = pb_inc;
                    if (r_ct == '0) begin
                        fin = 1'b1;
                    end else begin
                        n_phase = PH_BODY;
                    end
                end
            end else if (r_phase == PH_START) begin
                if (!is_status && !is_request) begin
                    fin  = 1'b1;
                    code = ST_BAD_START;
                end else begin
                    if (is_status) begin
                        n_mrun = '0;
                    end
                    n_phase  = PH_HEAD;
                    new_line = 1'b1;
                end
            end else if (r_ts != TS_VALUE) begin
                fin  = 1'b1;
                code = ST_BAD_HDR;
            end else begin
                new_line = 1'b1;
                if (hit_ok) begin
                    if (hit == TAG_CLEN) begin
                        if (r_found[TAG_CLEN]) begin
                            fin  = 1'b1;
                            code = ST_DUPLICATE;
                        end else if (!r_dv) begin
                            fin  = 1'b1;
                            code = ST_BAD_LEN;
                        end else begin
                            n_ct = r_acc;
                            n_found[TAG_CLEN] = 1'b1;
                        end
                    end else if (!r_found[hit]) begin
                        n_off[hit[1:0]] = PW'(r_ls + PW'(r_vb));
                        n_len[hit[1:0]] = LW'(r_ll - r_vb);
                        n_found[hit]    = 1'b1;
                    end else if (hit != TAG_CONTACT) begin
                        fin  = 1'b1;
                        code = ST_DUPLICATE;
                    end
                end
            end
        end

        if (new_line) begin
            n_ls = pb_inc; n_ll = '0; n_tl = '0; n_cand = '1; n_ts = TS_TAG;
            n_vb = '0; n_acc = '0; n_dv = 1'b0;
        end

        o_res = '0;
        o_res.status = code;
        if (code == ST_READY) begin
            o_res.header_len     = 14'(n_ht);
            o_res.body_len       = 14'(n_ct);
            o_res.method_len     = 13'(n_mrun);
            o_res.via_offset     = 14'(n_off[0]);
            o_res.via_length     = 13'(n_len[0]);
            o_res.from_offset    = 14'(n_off[1]);
            o_res.from_length    = 13'(n_len[1]);
            o_res.to_offset      = 14'(n_off[2]);
            o_res.to_length      = 13'(n_len[2]);
            o_res.contact_offset = 14'(n_off[3]);
            o_res.contact_length = 13'(n_len[3]);
        end

        if (fin || restart) begin
            n_phase = PH_START; n_pkt = '0; n_ls = '0; n_ll = '0; n_cr = 1'b0;
            n_first = '0; n_last = '0; n_mrun = '0; n_ms = MS_SCAN;
            n_tl = '0; n_cand = '1; n_ts = TS_TAG; n_vb = '0; n_acc = '0;
            n_dv = 1'b0; n_found = '0; n_ht = '0; n_ct = '0;
            for (int k = 0; k < 4; k++) begin
                n_off[k] = '0;
                n_len[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START; r_pkt <= '0; r_ls <= '0; r_ll <= '0; r_cr <= 1'b0;
            r_first <= '0; r_last <= '0; r_mrun <= '0; r_ms <= MS_SCAN;
            r_tl <= '0; r_cand <= '1; r_ts <= TS_TAG; r_vb <= '0; r_acc <= '0;
            r_dv <= 1'b0; r_found <= '0; r_ht <= '0; r_ct <= '0;
            for (int k = 0; k < 4; k++) begin
                r_off[k] <= '0;
                r_len[k] <= '0;
            end
        end else if (o_take) begin
            r_phase <= n_phase; r_pkt <= n_pkt; r_ls <= n_ls; r_ll <= n_ll;
            r_cr <= n_cr; r_first <= n_first; r_last <= n_last; r_mrun <= n_mrun;
            r_ms <= n_ms; r_tl <= n_tl; r_cand <= n_cand; r_ts <= n_ts;
            r_vb <= n_vb; r_acc <= n_acc; r_dv <= n_dv; r_found <= n_found;
            r_off <= n_off; r_len <= n_len; r_ht <= n_ht; r_ct <= n_ct;
        end
    end
endmodule
`default_nettype wire

### hw/rtl/sip_message_framer.sv
// SIP message framer. Bytes of a SIP stream enter one per transaction on the push side
// and one result per finished packet or per error leaves on the pop side. The block
// sustains one byte per clock: a two-entry byte queue feeds a parser that handles a
// whole byte at once, and a two-entry result queue decouples it from the
// reader, so the input stalls only when both queues fill. A result is written into the
// result queue when the parser takes the byte that completes it, and it can be popped
// from there. There is no clearing pass after reset.
`default_nettype none
module sip_message_framer
    import smf_pkg::*;
#(
    parameter int MAX_LINE   = MAX_LINE_DEF,
    parameter int MAX_PACKET = MAX_PACKET_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic [3:0]       o_status,
    output logic [13:0]      o_header_len,
    output logic [13:0]      o_body_len,
    output logic [12:0]      o_method_len,
    output logic [13:0]      o_via_offset,
    output logic [12:0]      o_via_length,
    output logic [13:0]      o_from_offset,
    output logic [12:0]      o_from_length,
    output logic [13:0]      o_to_offset,
    output logic [12:0]      o_to_length,
    output logic [13:0]      o_contact_offset,
    output logic [12:0]      o_contact_length
);
    localparam int RES_W = $bits(t_result);

    // The front end lower-cases and classifies each byte, then queues it.
    logic        cls_valid, cls_take;
    t_byte_class cls;

    smf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_data_byte),
        .o_full  (full),
        .o_valid (cls_valid),
        .o_cls   (cls),
        .i_take  (cls_take)
    );

    // The back end runs the framing state machine on each queued byte.
    logic             res_full, res_push;
    t_result          res, res_out;
    logic [RES_W-1:0] res_rdata;

    smf_back #(.MAX_LINE(MAX_LINE), .MAX_PACKET(MAX_PACKET)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (cls_valid),
        .i_cls      (cls),
        .o_take     (cls_take),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res)
    );

    // Results wait here until the reader pops them.
    smf_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_rdata (res_rdata)
    );

    assign res_out          = t_result'(res_rdata);
    assign o_status         = res_out.status;
    assign o_header_len     = res_out.header_len;
    assign o_body_len       = res_out.body_len;
    assign o_method_len     = res_out.method_len;
    assign o_via_offset     = res_out.via_offset;
    assign o_via_length     = res_out.via_length;
    assign o_from_offset    = res_out.from_offset;
    assign o_from_length    = res_out.from_length;
    assign o_to_offset      = res_out.to_offset;
    assign o_to_length      = res_out.to_length;
    assign o_contact_offset = res_out.contact_offset;
    assign o_contact_length = res_out.contact_length;
endmodule
`default_nettype wire

### hw/rtl/smf_checker.sv
`default_nettype none
module smf_checker
    import smf_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        full,
    input wire logic        empty,
    input wire logic        pop,
    input wire logic [3:0]  o_status,
    input wire logic [13:0] o_header_len,
    input wire logic [13:0] o_body_len,
    input wire logic [12:0] o_method_len,
    input wire logic [13:0] o_via_offset,
    input wire logic [13:0] o_contact_offset
);
    // Queues come out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_status <= ST_TOO_LARGE)
        else $error("status code out of range");

    // An error result carries only its code.
    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_READY) |-> (o_header_len == '0 && o_body_len == '0 &&
        o_method_len == '0 && o_via_offset == '0 && o_contact_offset == '0))
        else $error("error result with nonzero fields");

    // A ready packet always has a nonempty header.
    a_ready_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status == ST_READY) |-> o_header_len != '0)
        else $error("ready result with empty header");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_header_len)))
        else $error("waiting result changed");
endmodule

bind sip_message_framer smf_checker u_smf_checker (.*);
`default_nettype wire

### tb/sip_message_framer_tb.sv
`timescale 1ns / 100ps

module sip_message_framer_tb;
    import smf_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam logic [7:0] CR = 8'h0D;
    localparam logic [7:0] LF = 8'h0A;
    localparam logic [4:0] REQUIRED_TAGS =
        (5'd1 << TAG_VIA) | (5'd1 << TAG_FROM) | (5'd1 << TAG_TO) | (5'd1 << TAG_CLEN);

    logic        i_clk;
    logic        i_rst_n;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = 8'h00;
    logic        empty;
    logic        pop = 1'b0;
    logic [3:0]  o_status;
    logic [13:0] o_header_len;
    logic [13:0] o_body_len;
    logic [12:0] o_method_len;
    logic [13:0] o_via_offset;
    logic [12:0] o_via_length;
    logic [13:0] o_from_offset;
    logic [12:0] o_from_length;
    logic [13:0] o_to_offset;
    logic [12:0] o_to_length;
    logic [13:0] o_contact_offset;
    logic [12:0] o_contact_length;

    sip_message_framer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_data_byte(i_data_byte),
        .empty(empty), .pop(pop),
        .o_status(o_status), .o_header_len(o_header_len), .o_body_len(o_body_len),
        .o_method_len(o_method_len),
        .o_via_offset(o_via_offset), .o_via_length(o_via_length),
        .o_from_offset(o_from_offset), .o_from_length(o_from_length),
        .o_to_offset(o_to_offset), .o_to_length(o_to_length),
        .o_contact_offset(o_contact_offset), .o_contact_length(o_contact_length)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Byte stream to send, expected frame results, and status codes typed into
    // the directed table (-1 where the predictor alone decides).
    logic [7:0] byte_stream[$];
    t_result    pending_frames[$];
    int         typed_status[$];
    int         mismatches = 0;
    int         cycle_count = 0;
    logic       quiet;

    // Framer state kept by the predictor.
    logic [1:0]  ph;
    int unsigned pkt_bytes, ln_start, ln_len, meth_run, tag_pos, val_begin, len_acc;
    int unsigned hdr_total, body_total;
    logic        cr_seen, digits_ok;
    logic [63:0] head8, tail8;
    logic [1:0]  meth_st, tag_st;
    logic [4:0]  tag_cands, found;
    int unsigned loc[8];
    string       tag_names[5] = '{"via", "from", "to", "contact", "content-length"};

    task automatic reset_line();
        ln_start  = pkt_bytes;
        ln_len    = 0;
        tag_pos   = 0;
        tag_cands = 5'h1F;
        tag_st    = TS_TAG;
        val_begin = 0;
        len_acc   = 0;
        digits_ok = 1'b0;
    endtask

    task automatic clear_packet();
        ph         = PH_START;
        pkt_bytes  = 0;
        cr_seen    = 1'b0;
        head8      = '0;
        tail8      = '0;
        meth_run   = 0;
        meth_st    = MS_SCAN;
        found      = '0;
        hdr_total  = 0;
        body_total = 0;
        foreach (loc[k]) loc[k] = 0;
        reset_line();
    endtask

    task automatic emit_frame(input t_result r);
        int want;
        pending_frames.push_back(r);
        if (typed_status.size() > 0) begin
            want = typed_status.pop_front();
            if (want >= 0 && want != r.status) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("directed row: status %0d predicted, %0d listed", r.status, want);
                end
            end
        end
    endtask

    task automatic emit_fail(input logic [3:0] code);
        t_result r;
        r = '0;
        r.status = code;
        clear_packet();
        emit_frame(r);
    endtask

    task automatic emit_ready();
        t_result r;
        r.status         = ST_READY;
        r.header_len     = hdr_total[13:0];
        r.body_len       = body_total[13:0];
        r.method_len     = meth_run[12:0];
        r.via_offset     = loc[0][13:0];
        r.via_length     = loc[1][12:0];
        r.from_offset    = loc[2][13:0];
        r.from_length    = loc[3][12:0];
        r.to_offset      = loc[4][13:0];
        r.to_length      = loc[5][12:0];
        r.contact_offset = loc[6][13:0];
        r.contact_length = loc[7][12:0];
        clear_packet();
        emit_frame(r);
    endtask

    // Decimal Content-Length, saturating one past the largest packet.
    task automatic length_digit(input logic [7:0] lb, input logic first);
        logic is_digit;
        int unsigned v;
        is_digit = lb >= "0" && lb <= "9";
        if (first) begin
            digits_ok = is_digit;
            len_acc   = 0;
        end
        if (!is_digit) begin
            digits_ok = 1'b0;
        end else if (digits_ok) begin
            v = len_acc * 10 + (lb - "0");
            len_acc = (v > MAX_PACKET_DEF) ? MAX_PACKET_DEF + 1 : v;
        end
    endtask

    task automatic line_done();
        logic status_line, request;
        int hit;
        if (ln_len == 0) begin
            if (ph == PH_START) begin
                clear_packet();
            end else if ((found & REQUIRED_TAGS) != REQUIRED_TAGS) begin
                emit_fail(ST_MISSING);
            end else begin
                hdr_total = pkt_bytes;
                if (body_total == 0) emit_ready();
                else ph = PH_BODY;
            end
            return;
        end
        if (ph == PH_START) begin
            status_line = ln_len > 8 && head8 == STATUS_WORD;
            request     = ln_len > 8 && tail8 == REQUEST_TAIL && meth_st == MS_OK;
            if (!status_line && !request) begin
                emit_fail(ST_BAD_START);
                return;
            end
            if (status_line) meth_run = 0;
            ph = PH_HEAD;
        end else begin
            if (tag_st != TS_VALUE) begin
                emit_fail(ST_BAD_HDR);
                return;
            end
            hit = -1;
            for (int k = 0; k < NUM_TAGS; k++) begin
                if (tag_cands[k] && tag_pos == tag_names[k].len()) hit = k;
            end
            if (hit == TAG_CLEN) begin
                if (found[TAG_CLEN]) begin
                    emit_fail(ST_DUPLICATE);
                    return;
                end
                if (!digits_ok) begin
                    emit_fail(ST_BAD_LEN);
                    return;
                end
                body_total = len_acc;
                found[TAG_CLEN] = 1'b1;
            end else if (hit >= 0 && !found[hit]) begin
                loc[2 * hit]     = ln_start + val_begin;
                loc[2 * hit + 1] = ln_len - val_begin;
                found[hit] = 1'b1;
            end else if (hit >= 0 && hit != TAG_CONTACT) begin
                // A repeated Contact line is simply ignored; other repeats are errors.
                emit_fail(ST_DUPLICATE);
                return;
            end
        end
        reset_line();
    endtask

    task automatic frame_byte(input logic [7:0] b);
        logic [7:0] lb;
        int unsigned pos;
        if (pkt_bytes + 1 > MAX_PACKET_DEF) begin
            emit_fail(ST_TOO_LARGE);
            return;
        end
        pkt_bytes++;
        if (ph == PH_BODY) begin
            if (pkt_bytes >= hdr_total + body_total) emit_ready();
            return;
        end
        if (cr_seen) begin
            cr_seen = 1'b0;
            if (b != LF) emit_fail(ST_LONE_CR);
            else line_done();
            return;
        end
        if (b == CR) begin
            cr_seen = 1'b1;
            return;
        end
        if (b == LF) begin
            line_done();
            return;
        end
        if (ln_len + 1 > MAX_LINE_DEF) begin
            emit_fail(ST_LONG_LINE);
            return;
        end
        pos = ln_len;
        ln_len++;
        lb = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
        if (ph == PH_START) begin
            // Start line: keep the first and the last eight bytes and scan the method.
            if (pos < 8) head8[8 * pos +: 8] = lb;
            tail8 = {tail8[55:0], lb};
            if (meth_st == MS_SCAN) begin
                if (lb >= "a" && lb <= "z") meth_run++;
                else if (lb == " " && meth_run > 0) meth_st = MS_OK;
                else meth_st = MS_BAD;
            end
        end else if (tag_st == TS_TAG) begin
            if ((lb >= "a" && lb <= "z") || lb == "-") begin
                for (int k = 0; k < NUM_TAGS; k++) begin
                    if (tag_pos >= tag_names[k].len() || tag_names[k][tag_pos] != lb) begin
                        tag_cands[k] = 1'b0;
                    end
                end
                if (tag_pos < 15) tag_pos++;
            end else if (lb == ":" && tag_pos > 0) begin
                tag_st = TS_SPACE;
            end else begin
                tag_st = TS_BAD;
            end
        end else if (tag_st == TS_SPACE) begin
            if (lb != " ") begin
                tag_st = TS_VALUE;
                val_begin = pos;
                length_digit(lb, 1'b1);
            end
        end else if (tag_st == TS_VALUE) begin
            length_digit(lb, 1'b0);
        end
    endtask

    // Stimulus helpers. In directed text a tilde stands for a carriage return.
    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            byte_stream.push_back(s[i] == "~" ? CR : s[i]);
        end
    endtask

    task automatic add_raw(input string s);
        for (int i = 0; i < s.len(); i++) byte_stream.push_back(s[i]);
    endtask

    function automatic string mix_case(input string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++) begin
            if (r[i] >= "a" && r[i] <= "z" && $urandom_range(1) == 1) r[i] = r[i] - 8'd32;
        end
        return r;
    endfunction

    function automatic string rand_text(input int n);
        string r;
        r = "";
        for (int i = 0; i < n; i++) begin
            r = {r, string'(byte'(i == 0 ? $urandom_range(8'h21, 8'h7E)
                                          : $urandom_range(8'h20, 8'h7E)))};
        end
        return r;
    endfunction

    task automatic add_eol();
        int pick;
        pick = $urandom_range(99);
        if (pick < 2) begin
            byte_stream.push_back(CR);
            byte_stream.push_back(8'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 50) begin
            byte_stream.push_back(CR);
            byte_stream.push_back(LF);
        end else begin
            byte_stream.push_back(LF);
        end
    endtask

    // One random packet: mostly well formed, sometimes broken in one or more places.
    task automatic add_message();
        string lines[$];
        string tmp, meth;
        int    body, drop, pick;
        repeat ($urandom_range(0, 2)) add_eol();
        pick = $urandom_range(99);
        if (pick < 45) begin
            add_raw({mix_case("sip/2.0 "), rand_text($urandom_range(1, 8))});
        end else if (pick < 95) begin
            meth = "";
            repeat ($urandom_range(1, 7)) meth = {meth, string'(byte'($urandom_range("a", "z")))};
            add_raw({mix_case(meth), " ", rand_text($urandom_range(0, 6)), mix_case(" sip/2.0")});
        end else begin
            add_raw({"SIP/2.1 ", rand_text($urandom_range(0, 6))});
        end
        add_eol();
        body = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 24);
        lines.push_back({mix_case("via"), ":"});
        lines.push_back({mix_case("from"), ":"});
        lines.push_back({mix_case("to"), ":"});
        tmp.itoa(body);
        lines.push_back({mix_case("content-length"), ":", ($urandom_range(24) == 0) ? "1a" : tmp});
        drop = ($urandom_range(19) == 0) ? $urandom_range(3) : -1;
        if (drop >= 0) lines.delete(drop);
        if ($urandom_range(19) == 0) lines.push_back(lines[$urandom_range(lines.size() - 1)]);
        repeat ($urandom_range(0, 2)) lines.push_back({mix_case("contact"), ":"});
        if ($urandom_range(4) == 0) lines.push_back({mix_case("x-tag"), ":"});
        if ($urandom_range(29) == 0) lines.push_back("Bad Header");
        for (int i = lines.size() - 1; i > 0; i--) begin
            pick = $urandom_range(i);
            tmp = lines[i];
            lines[i] = lines[pick];
            lines[pick] = tmp;
        end
        foreach (lines[i]) begin
            add_raw(lines[i]);
            if (lines[i][lines[i].len() - 1] == ":" || lines[i][lines[i].len() - 2] == ":"
                || lines[i].len() > 16) begin
                repeat ($urandom_range(0, 3)) byte_stream.push_back(" ");
            end
            // Content-Length lines already carry their value.
            if (lines[i].len() < 15) add_raw(rand_text($urandom_range(1, 10)));
            add_eol();
        end
        add_eol();
        repeat (body) byte_stream.push_back(8'($urandom_range(255)));
    endtask

    // Directed table: each row leaves exactly one result behind.
    typedef struct {
        string txt;
        int    status;
    } t_row;

    localparam string HDRS = "Via: a\nFrom: b\nTo: c\n";
    t_row directed_rows[] = '{
        '{"SIP/2.0 200 OK~\nVia: a~\nFrom: b~\nTo: c~\nContent-Length: 0~\n~\n", ST_READY},
        '{{"~\n\nINVITE sip:a SIP/2.0\nvia:x\nFROM:  y\nto:z\ncontact:c\nContact:d\n",
           "content-length: 3\n\nabc"}, ST_READY},
        '{{"SIP/2.0 180 Ringing\nX-Foo: 1\nContact: <a>\n", HDRS,
           "CONTENT-LENGTH: 2\n\n~\n"}, ST_READY},
        '{{"zz SIP/2.0\n", HDRS, "Content-Length: 0\n\n"}, -1},
        '{"SIP/2.0\n", ST_BAD_START},
        '{"INV1TE x SIP/2.0\n", ST_BAD_START},
        '{"SIP/2.0 200 OK~\nVia: a~X", ST_LONE_CR},
        '{"SIP/2.0 200 OK\nVia a\n", ST_BAD_HDR},
        '{"SIP/2.0 200 OK\n: x\n", ST_BAD_HDR},
        '{"SIP/2.0 200 OK\nVia:\n", ST_BAD_HDR},
        '{"SIP/2.0 200 OK\nVia: a\nvia: b\n", ST_DUPLICATE},
        '{"SIP/2.0 200 OK\nContent-Length: 0\ncontent-length: 0\n", ST_DUPLICATE},
        '{"SIP/2.0 200 OK\nContent-Length: 1x\n", ST_BAD_LEN},
        '{"SIP/2.0 200 OK\nVia: a\n\n", ST_MISSING}
    };

    // Result checking, one field at a time.
    function automatic void check_field(input string nm, input int want, input int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10) $display("%s: expected %0d, got %0d", nm, want, got);
        end
    endfunction

    assign quiet = (cycle_count % 4000) < 1500;

    // Sender side: a transaction completes when push is high and full is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push        <= 1'b0;
            i_data_byte <= 8'h00;
        end else begin
            if (push && !full) frame_byte(i_data_byte);
            if (!push || !full) begin
                if (byte_stream.size() > 0 && (quiet || $urandom_range(99) >= 9)) begin
                    push        <= 1'b1;
                    i_data_byte <= byte_stream.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Receiver side: compare each popped result with the oldest expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_frames.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result, status %0d", o_status);
                end else begin
                    want = pending_frames.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("header_len", want.header_len, o_header_len);
                    check_field("body_len", want.body_len, o_body_len);
                    check_field("method_len", want.method_len, o_method_len);
                    check_field("via_offset", want.via_offset, o_via_offset);
                    check_field("via_length", want.via_length, o_via_length);
                    check_field("from_offset", want.from_offset, o_from_offset);
                    check_field("from_length", want.from_length, o_from_length);
                    check_field("to_offset", want.to_offset, o_to_offset);
                    check_field("to_length", want.to_length, o_to_length);
                    check_field("contact_offset", want.contact_offset, o_contact_offset);
                    check_field("contact_length", want.contact_length, o_contact_length);
                end
            end
            pop <= quiet || $urandom_range(99) >= 9;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int    messages;
        int    hdr_len;
        string big;
        i_rst_n = 1'b0;
        clear_packet();

        foreach (directed_rows[i]) begin
            add_text(directed_rows[i].txt);
            typed_status.push_back(directed_rows[i].status);
        end
        // A start line one byte past the line limit.
        repeat (MAX_LINE_DEF + 1) byte_stream.push_back("a");
        typed_status.push_back(ST_LONG_LINE);
        // A length that saturates, so the body runs one byte past the packet limit.
        big = {"SIP/2.0 200 OK\n", HDRS, "Content-Length: 99999\n\n"};
        hdr_len = big.len();
        add_text(big);
        repeat (MAX_PACKET_DEF + 1 - hdr_len) byte_stream.push_back(8'($urandom_range(255)));
        typed_status.push_back(ST_TOO_LARGE);

        messages = 0;
        while (byte_stream.size() < MAX_LINE_DEF + MAX_PACKET_DEF + 2200 || messages < 20) begin
            if ($urandom_range(19) == 0) begin
                repeat ($urandom_range(1, 20)) byte_stream.push_back(8'($urandom_range(255)));
            end
            add_message();
            messages++;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (byte_stream.size() == 0 && !push);
        wait (pending_frames.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending_frames.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
